// ===== hdl/krss_pkg.sv =====
// ----------------------------------------------------------------------------
// krss_pkg: shared types and constants
// Item, table entry and result types of the keyed return statistics block.
// ----------------------------------------------------------------------------
package krss_pkg;

    localparam logic [20:0] MAX_SAMPLES = 21'd1048576;
    localparam logic signed [23:0] RATIO_TEN = 24'sd655360;
    localparam logic signed [23:0] Q24_MAX = 24'sd8388607;
    localparam logic signed [23:0] Q24_MIN = -24'sd8388608;

    typedef struct packed {
        logic               query;
        logic               key_ok;
        logic [13:0]        key;
        logic signed [23:0] ret;
        logic               won;
    } item_t;

    typedef struct packed {
        logic [20:0]        count;
        logic [20:0]        wins;
        logic signed [43:0] sum;
        logic [63:0]        sq;
        logic signed [23:0] maxv;
        logic signed [23:0] minv;
    } entry_t;

    typedef struct packed {
        logic               qualifies;
        logic [20:0]        sample_count;
        logic [20:0]        win_count;
        logic [20:0]        loss_count;
        logic signed [23:0] avg_return;
        logic [22:0]        dev_return;
        logic signed [23:0] ratio;
        logic [16:0]        win_ratio;
        logic signed [23:0] max_return;
        logic signed [23:0] min_return;
        logic [2:0]         ratio_bucket;
    } result_t;

endpackage

// ===== hdl/keyed_return_stats_sharpe_top.sv =====
// ----------------------------------------------------------------------------
// keyed_return_stats_sharpe_top: keyed return statistics table
// Per-key count, wins, sum, square sum and extremes, with query statistics.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries add and query transactions.
// An add updates the entry of key_id and gives no result; a query gives one
// result transaction on the output channel (out_valid/out_ready).
// A two-entry queue parts the acceptance side from the table sequencer.
// An add makes one table read and one write in the sequencer.
// A query runs four divisions on the shared divider and a square root;
// with zero deviation the ratio division is skipped, and an empty entry
// answers without any division or square root.
// After reset the table is cleared one entry a cycle while in_ready stays low;
// min_trade_count resets to 5 and is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// When the receiver stalls, the result holds and the queue keeps accepting
// until it holds two transactions.
// ----------------------------------------------------------------------------
module keyed_return_stats_sharpe_top
#(
    parameter int KEY_COUNT = 16384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [20:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [13:0]        key_id,
    input  logic signed [23:0] return_value,
    input  logic               won_flag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               qualifies,
    output logic [20:0]        sample_count,
    output logic [20:0]        win_count,
    output logic [20:0]        loss_count,
    output logic signed [23:0] avg_return,
    output logic [22:0]        dev_return,
    output logic signed [23:0] ratio,
    output logic [16:0]        win_ratio,
    output logic signed [23:0] max_return,
    output logic signed [23:0] min_return,
    output logic [2:0]         ratio_bucket
);

    logic              cfg_write;
    logic [20:0]       min_count_reg;
    logic              clearing;
    logic              q_valid;
    logic              q_pop;
    krss_pkg::item_t   q_item;
    krss_pkg::result_t res;

    assign cfg_write = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg <= 21'd5;
        end
        else if (cfg_write)
        begin
            min_count_reg <= cfg_wdata;
        end
    end

    krss_front #(.KEY_COUNT(KEY_COUNT)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .key_id       (key_id),
        .return_value (return_value),
        .won_flag     (won_flag),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    krss_back #(.KEY_COUNT(KEY_COUNT)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .min_trade_count (min_count_reg),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .res             (res)
    );

    assign qualifies    = res.qualifies;
    assign sample_count = res.sample_count;
    assign win_count    = res.win_count;
    assign loss_count   = res.loss_count;
    assign avg_return   = res.avg_return;
    assign dev_return   = res.dev_return;
    assign ratio        = res.ratio;
    assign win_ratio    = res.win_ratio;
    assign max_return   = res.max_return;
    assign min_return   = res.min_return;
    assign ratio_bucket = res.ratio_bucket;

endmodule

// ===== hdl/krss_div.sv =====
// ----------------------------------------------------------------------------
// krss_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module krss_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [32:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[63]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 32'd0;
            quo_next  = dividend;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/krss_sqrt.sv =====
// ----------------------------------------------------------------------------
// krss_sqrt: iterative integer square root
// Floor square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module krss_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [33:0] rem_reg;
    logic [33:0] rem_next;
    logic [31:0] root_reg;
    logic [31:0] root_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [35:0] shifted;
    logic [35:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, x_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = 34'd0;
            root_next = 32'd0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[61:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = 34'(shifted - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/krss_front.sv =====
// ----------------------------------------------------------------------------
// krss_front: input acceptance and item queue
// Accepts transactions, checks the key range and queues items for the back end.
// ----------------------------------------------------------------------------
module krss_front
#(
    parameter int KEY_COUNT = 16384
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [13:0]         key_id,
    input  logic signed [23:0]  return_value,
    input  logic                won_flag,
    input  logic                clearing,
    output logic                q_valid,
    output krss_pkg::item_t     q_item,
    input  logic                q_pop
);

    krss_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push;
    krss_pkg::item_t new_item;

    always_comb
    begin
        new_item.query  = action;
        new_item.key_ok = ({18'd0, key_id} < 32'(KEY_COUNT));
        new_item.key    = key_id;
        new_item.ret    = return_value;
        new_item.won    = won_flag;
    end

    assign in_ready = (cnt_reg != 2'd2) && !clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hdl/krss_back.sv =====
// ----------------------------------------------------------------------------
// krss_back: statistics table and query sequencer
// Holds the per-key table, applies add items and computes query results.
// ----------------------------------------------------------------------------
module krss_back
#(
    parameter int KEY_COUNT = 16384
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  krss_pkg::item_t     q_item,
    output logic                q_pop,
    input  logic [20:0]         min_trade_count,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_ready,
    output krss_pkg::result_t   res
);

    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ADD    = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_MEAN_W = 4'd4;
    localparam logic [3:0] S_E2_S   = 4'd5;
    localparam logic [3:0] S_E2_W   = 4'd6;
    localparam logic [3:0] S_VAR    = 4'd7;
    localparam logic [3:0] S_SQRT_W = 4'd8;
    localparam logic [3:0] S_RAT_S  = 4'd9;
    localparam logic [3:0] S_RAT_W  = 4'd10;
    localparam logic [3:0] S_RATE_S = 4'd11;
    localparam logic [3:0] S_RATE_W = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    krss_pkg::entry_t mem [KEY_COUNT];
    krss_pkg::entry_t rd_data_reg;
    krss_pkg::entry_t wr_data;
    logic [KW-1:0]    wr_addr;
    logic             wr_en;
    logic [KW-1:0]    rd_addr;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [KW-1:0]    clr_addr_reg;
    krss_pkg::item_t  cur_reg;
    logic [39:0]      sqinc_reg;
    logic [20:0]      n_reg;
    logic [20:0]      wins_reg;
    logic [63:0]      sq_reg;
    logic signed [23:0] max_reg;
    logic signed [23:0] min_reg;
    logic signed [23:0] mean_reg;
    logic [39:0]      m2_reg;
    logic [63:0]      e2_reg;
    logic [22:0]      std_reg;
    logic signed [23:0] ratio_reg;
    logic [16:0]      rate_reg;

    logic signed [47:0] sq_prod;
    logic signed [47:0] m2_prod;
    logic [20:0]      n_ld;
    logic [43:0]      sum_mag;
    logic [23:0]      mean_mag;
    logic [63:0]      var_val;
    logic [22:0]      std_clamp;
    logic signed [23:0] add_r;

    logic             div_start;
    logic [63:0]      div_dividend;
    logic [31:0]      div_divisor;
    logic             div_done;
    logic [63:0]      div_q;
    logic             sqrt_start;
    logic             sqrt_done;
    logic [31:0]      sqrt_root;

    krss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    krss_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({var_val[55:0], 8'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign rd_addr = KW'(q_item.key);
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign sq_prod = q_item.ret * q_item.ret;
    assign m2_prod = mean_reg * mean_reg;
    assign n_ld    = cur_reg.key_ok ? rd_data_reg.count : 21'd0;
    assign sum_mag = rd_data_reg.sum[43] ? 44'(44'd0 - rd_data_reg.sum) : rd_data_reg.sum;
    assign mean_mag = mean_reg[23] ? 24'(24'd0 - mean_reg) : mean_reg;
    assign var_val = (e2_reg > {24'd0, m2_reg}) ? 64'(e2_reg - {24'd0, m2_reg}) : 64'd0;
    assign std_clamp = (sqrt_root > 32'd8388607) ? 23'h7FFFFF : sqrt_root[22:0];
    assign add_r   = cur_reg.ret;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = 32'd1;
        case (state_reg)
            S_LOAD:
            begin
                div_start    = (n_ld != 21'd0);
                div_dividend = 64'(sum_mag) + 64'(n_ld[20:1]);
                div_divisor  = 32'(n_ld);
            end
            S_E2_S:
            begin
                div_start    = 1'b1;
                div_dividend = sq_reg;
                div_divisor  = 32'(n_reg);
            end
            S_RAT_S:
            begin
                div_start    = 1'b1;
                div_dividend = 64'({mean_mag, 16'd0}) + 64'(std_reg[22:1]);
                div_divisor  = 32'(std_reg);
            end
            S_RATE_S:
            begin
                div_start    = 1'b1;
                div_dividend = 64'({wins_reg, 17'd0}) + 64'(n_reg);
                div_divisor  = 32'({n_reg, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == S_VAR);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = KW'(cur_reg.key);
        wr_data = rd_data_reg;
        if (state_reg == S_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_ADD)
        begin
            wr_en         = cur_reg.key_ok && (rd_data_reg.count < krss_pkg::MAX_SAMPLES);
            wr_data.count = rd_data_reg.count + 21'd1;
            wr_data.wins  = rd_data_reg.wins + {20'd0, cur_reg.won};
            wr_data.sum   = rd_data_reg.sum + {{20{add_r[23]}}, add_r};
            wr_data.sq    = rd_data_reg.sq + {24'd0, sqinc_reg};
            if ((rd_data_reg.count == 21'd0) || (add_r > $signed(rd_data_reg.maxv)))
            begin
                wr_data.maxv = add_r;
            end
            if ((rd_data_reg.count == 21'd0) || (add_r < $signed(rd_data_reg.minv)))
            begin
                wr_data.minv = add_r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_addr_reg == KW'(KEY_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.query ? S_LOAD : S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_IDLE;
            end
            S_LOAD:
            begin
                state_next = (n_ld == 21'd0) ? S_OUT : S_MEAN_W;
            end
            S_MEAN_W:
            begin
                if (div_done)
                begin
                    state_next = S_E2_S;
                end
            end
            S_E2_S:
            begin
                state_next = S_E2_W;
            end
            S_E2_W:
            begin
                if (div_done)
                begin
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                state_next = S_SQRT_W;
            end
            S_SQRT_W:
            begin
                if (sqrt_done)
                begin
                    state_next = (std_clamp == 23'd0) ? S_RATE_S : S_RAT_S;
                end
            end
            S_RAT_S:
            begin
                state_next = S_RAT_W;
            end
            S_RAT_W:
            begin
                if (div_done)
                begin
                    state_next = S_RATE_S;
                end
            end
            S_RATE_S:
            begin
                state_next = S_RATE_W;
            end
            S_RATE_W:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_addr_reg <= clr_addr_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m2_reg <= m2_prod[47:8];
        if (q_pop)
        begin
            cur_reg   <= q_item;
            sqinc_reg <= sq_prod[47:8];
        end
        if (state_reg == S_LOAD)
        begin
            n_reg    <= n_ld;
            wins_reg <= cur_reg.key_ok ? rd_data_reg.wins : 21'd0;
            sq_reg   <= rd_data_reg.sq;
            if (n_ld == 21'd0)
            begin
                mean_reg  <= '0;
                std_reg   <= '0;
                ratio_reg <= -krss_pkg::RATIO_TEN;
                rate_reg  <= '0;
                max_reg   <= '0;
                min_reg   <= '0;
            end
            else
            begin
                max_reg <= rd_data_reg.maxv;
                min_reg <= rd_data_reg.minv;
            end
        end
        if ((state_reg == S_MEAN_W) && div_done)
        begin
            mean_reg <= rd_data_reg.sum[43] ? 24'(24'd0 - div_q[23:0]) : div_q[23:0];
        end
        if ((state_reg == S_E2_W) && div_done)
        begin
            e2_reg <= div_q;
        end
        if ((state_reg == S_SQRT_W) && sqrt_done)
        begin
            std_reg <= std_clamp;
            if (std_clamp == 23'd0)
            begin
                ratio_reg <= (mean_reg > 24'sd0) ? krss_pkg::RATIO_TEN : -krss_pkg::RATIO_TEN;
            end
        end
        if ((state_reg == S_RAT_W) && div_done)
        begin
            if (!mean_reg[23])
            begin
                ratio_reg <= (div_q > 64'd8388607) ? krss_pkg::Q24_MAX : div_q[23:0];
            end
            else
            begin
                ratio_reg <= (div_q > 64'd8388608) ? krss_pkg::Q24_MIN
                                                    : 24'(24'd0 - div_q[23:0]);
            end
        end
        if ((state_reg == S_RATE_W) && div_done)
        begin
            rate_reg <= div_q[16:0];
        end
    end

    always_comb
    begin
        res.qualifies    = (n_reg >= min_trade_count);
        res.sample_count = n_reg;
        res.win_count    = wins_reg;
        res.loss_count   = n_reg - wins_reg;
        res.avg_return   = mean_reg;
        res.dev_return   = std_reg;
        res.ratio        = ratio_reg;
        res.win_ratio    = rate_reg;
        res.max_return   = max_reg;
        res.min_return   = min_reg;
        if (ratio_reg < -24'sd65536)
        begin
            res.ratio_bucket = 3'd0;
        end
        else if (ratio_reg < -24'sd32768)
        begin
            res.ratio_bucket = 3'd1;
        end
        else if (ratio_reg < 24'sd0)
        begin
            res.ratio_bucket = 3'd2;
        end
        else if (ratio_reg < 24'sd32768)
        begin
            res.ratio_bucket = 3'd3;
        end
        else if (ratio_reg < 24'sd65536)
        begin
            res.ratio_bucket = 3'd4;
        end
        else if (ratio_reg < 24'sd131072)
        begin
            res.ratio_bucket = 3'd5;
        end
        else
        begin
            res.ratio_bucket = 3'd6;
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign clearing  = (state_reg == S_CLR);

endmodule

// ===== hdl/krss_checker.sv =====
// ----------------------------------------------------------------------------
// krss_checker: port-level assertions
// Checks result consistency and output hold behavior on the top-level ports.
// ----------------------------------------------------------------------------
module krss_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [20:0]        sample_count,
    input logic [20:0]        win_count,
    input logic [20:0]        loss_count,
    input logic signed [23:0] avg_return,
    input logic [22:0]        dev_return,
    input logic signed [23:0] ratio,
    input logic [2:0]         ratio_bucket
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ratio) && $stable(sample_count))
        else $error("Result changed while stalled.");

    a_loss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (loss_count == 21'(sample_count - win_count)))
        else $error("Loss count does not match count minus wins.");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sample_count == 21'd0) |->
            (avg_return == 24'sd0) && (dev_return == 23'd0) && (ratio_bucket == 3'd0))
        else $error("Empty entry gave nonzero statistics.");

    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sample_count != 21'd0) && (dev_return == 23'd0) |->
            (ratio == 24'sd655360) || (ratio == -24'sd655360))
        else $error("Zero deviation without the fixed ratio.");

endmodule

bind keyed_return_stats_sharpe_top krss_checker u_krss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_count (sample_count),
    .win_count    (win_count),
    .loss_count   (loss_count),
    .avg_return   (avg_return),
    .dev_return   (dev_return),
    .ratio        (ratio),
    .ratio_bucket (ratio_bucket)
);
